[hdl/v3a_pkg.sv]
`default_nettype none

package v3a_pkg;

    // Fixed field widths
    localparam int COMP_W = 32;
    localparam int MODE_W = 3;
    localparam int ST_W   = 2;

    // Internal datapath widths (follow from the 32-bit components)
    localparam int AS_W   = COMP_W + 1;        // add / subtract
    localparam int PROD_W = 2 * COMP_W;        // one full product
    localparam int SUM_W  = PROD_W + 2;        // sum of up to three products
    localparam int SQ_W   = PROD_W;            // sum of squares, never wraps
    localparam int ROOT_W = SQ_W / 2;          // integer square root
    localparam int REM_W  = ROOT_W + 2;        // square root remainder
    localparam int MAG_W  = ROOT_W + 1;        // rounded magnitude

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCALE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NORM  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MAG   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DOT   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CROSS = 3'd6;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [COMP_W-1:0] ax;
        logic signed [COMP_W-1:0] ay;
        logic signed [COMP_W-1:0] az;
        logic signed [COMP_W-1:0] bx;
        logic signed [COMP_W-1:0] by;
        logic signed [COMP_W-1:0] bz;
        logic signed [COMP_W-1:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] result_x;
        logic signed [COMP_W-1:0] result_y;
        logic signed [COMP_W-1:0] result_z;
        logic [ST_W-1:0]          status;
    } out_t;

    // Front end output: products and sums after the multiplier stage
    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [2:0][COMP_W-1:0]     a;
        logic [2:0][AS_W-1:0]       addsub;
        logic [5:0][PROD_W-1:0]     p;
    } mul_t;

endpackage

`default_nettype wire

[hdl/vector3_alu.sv]
// Channel   | Signals              | Transfer
// ----------+----------------------+-----------------------------------------
// command   | start, busy, cmd     | taken when start is high and busy is low
// result    | done, result         | one cycle, taken at the edge ending it
//
// One transaction per cycle; busy never rises. Every operation passes
// through the 32-stage square root and the divider stages so that
// results stay in order.
// Reset clears the valid bits only; no clearing pass is needed.
// The result side has no stall: a result is shown once, for one cycle.
`default_nettype none

module vector3_alu #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire v3a_pkg::in_t   cmd,
    output logic                done,
    output v3a_pkg::out_t       result
);

    localparam int DW  = DATA_WIDTH;
    localparam int CW  = v3a_pkg::COMP_W;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NW  = v3a_pkg::MAG_W + FRAC_BITS;
    localparam int SMW = v3a_pkg::SUM_W;
    localparam logic signed [SMW-1:0] HALF = SMW'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [v3a_pkg::MODE_W-1:0] mode;
        logic [2:0][CW-1:0]         a;
        logic [2:0][DW-1:0]         early;
        logic                       sat;
    } sq_side_t;

    typedef struct packed {
        logic [v3a_pkg::MODE_W-1:0] mode;
        logic [2:0][DW-1:0]         early;
        logic                       sat;
        logic [DW-1:0]              mag;
        logic                       mag_sat;
        logic                       zero;
        logic [2:0]                 neg;
    } dv_side_t;

    // ---------------- front end: multipliers ----------------
    logic          mul_valid;
    v3a_pkg::mul_t mul_out;

    assign busy = 1'b0;

    v3a_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .cmd       (cmd),
        .out_valid (mul_valid),
        .out       (mul_out)
    );

    // ---------------- stage 3: product sums ----------------
    logic                          s3_valid_reg;
    logic [v3a_pkg::MODE_W-1:0]    s3_mode_reg;
    logic [2:0][CW-1:0]            s3_a_reg;
    logic [2:0][v3a_pkg::AS_W-1:0] s3_addsub_reg;
    logic signed [SMW-1:0]         s3_sum_reg [3];
    logic signed [SMW-1:0]         s3_sum_next [3];
    logic [v3a_pkg::SQ_W-1:0]      s3_sq_reg;
    logic [v3a_pkg::SQ_W-1:0]      s3_sq_next;

    always_comb
    begin
        logic signed [SMW-1:0] pe [6];
        for (int i = 0; i < 6; i++)
        begin
            pe[i] = SMW'($signed(mul_out.p[i]));
        end
        s3_sq_next = mul_out.p[0] + mul_out.p[1] + mul_out.p[2];
        s3_sum_next[0] = pe[0];
        s3_sum_next[1] = pe[1];
        s3_sum_next[2] = pe[2];
        unique case (mul_out.mode)
            v3a_pkg::MODE_DOT:
            begin
                s3_sum_next[0] = pe[0] + pe[1] + pe[2];
            end
            v3a_pkg::MODE_CROSS:
            begin
                s3_sum_next[0] = pe[0] - pe[1];
                s3_sum_next[1] = pe[2] - pe[3];
                s3_sum_next[2] = pe[4] - pe[5];
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- stage 4: rounding and saturation ----------------
    logic signed [SMW-1:0] rnd [3];
    logic signed [DW-1:0]  as_val [3];
    logic signed [DW-1:0]  rn_val [3];
    logic [2:0]            as_ovf;
    logic [2:0]            rn_ovf;

    always_comb
    begin
        logic signed [SMW-1:0] t;
        for (int i = 0; i < 3; i++)
        begin
            t      = s3_sum_reg[i] + HALF;
            rnd[i] = t >>> FRAC_BITS;
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_sat4
        v3a_sat #(.IN_W(v3a_pkg::AS_W), .OUT_W(DW)) u_sat_as (
            .din  ($signed(s3_addsub_reg[g])),
            .dout (as_val[g]),
            .ovf  (as_ovf[g])
        );
        v3a_sat #(.IN_W(SMW), .OUT_W(DW)) u_sat_rn (
            .din  (rnd[g]),
            .dout (rn_val[g]),
            .ovf  (rn_ovf[g])
        );
    end

    logic     s4_valid_reg;
    sq_side_t s4_side_reg;
    sq_side_t s4_side_next;
    logic [v3a_pkg::SQ_W-1:0] s4_sq_reg;

    always_comb
    begin
        s4_side_next.mode  = s3_mode_reg;
        s4_side_next.a     = s3_a_reg;
        s4_side_next.early = '0;
        s4_side_next.sat   = 1'b0;
        unique case (s3_mode_reg)
            v3a_pkg::MODE_ADD, v3a_pkg::MODE_SUB:
            begin
                s4_side_next.early = {as_val[2], as_val[1], as_val[0]};
                s4_side_next.sat   = |as_ovf;
            end
            v3a_pkg::MODE_SCALE, v3a_pkg::MODE_CROSS:
            begin
                s4_side_next.early = {rn_val[2], rn_val[1], rn_val[0]};
                s4_side_next.sat   = |rn_ovf;
            end
            v3a_pkg::MODE_DOT:
            begin
                s4_side_next.early[0] = rn_val[0];
                s4_side_next.sat      = rn_ovf[0];
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- square root ----------------
    logic                        sq_valid;
    logic [v3a_pkg::MAG_W-1:0]   sq_mag;
    sq_side_t                    sq_side;

    v3a_sqrt #(.SIDE_W($bits(sq_side_t))) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .sq        (s4_sq_reg),
        .in_side   (s4_side_reg),
        .out_valid (sq_valid),
        .mag       (sq_mag),
        .out_side  (sq_side)
    );

    // ---------------- stage 5: divider set-up ----------------
    logic signed [DW-1:0] mag_val;
    logic                 mag_ovf;
    logic [2:0][NW-1:0]   num_next;
    dv_side_t             p5_side_next;

    v3a_sat #(.IN_W(v3a_pkg::MAG_W + 1), .OUT_W(DW)) u_sat_mag (
        .din  ($signed({1'b0, sq_mag})),
        .dout (mag_val),
        .ovf  (mag_ovf)
    );

    always_comb
    begin
        logic [CW-1:0] absv;
        p5_side_next.mode    = sq_side.mode;
        p5_side_next.early   = sq_side.early;
        p5_side_next.sat     = sq_side.sat;
        p5_side_next.mag     = mag_val;
        p5_side_next.mag_sat = mag_ovf;
        p5_side_next.zero    = (sq_mag == '0);
        for (int i = 0; i < 3; i++)
        begin
            p5_side_next.neg[i] = sq_side.a[i][CW-1];
            absv = sq_side.a[i][CW-1] ? (~sq_side.a[i] + 1'b1) : sq_side.a[i];
            num_next[i] = (NW'(absv) << FRAC_BITS) + NW'(sq_mag >> 1);
        end
    end

    logic                       p5_valid_reg;
    dv_side_t                   p5_side_reg;
    logic [2:0][NW-1:0]         p5_num_reg;
    logic [v3a_pkg::MAG_W-1:0]  p5_den_reg;

    // ---------------- divider ----------------
    logic               dv_valid;
    logic [2:0][QW-1:0] dv_quo;
    dv_side_t           dv_side;

    v3a_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(dv_side_t))) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p5_valid_reg),
        .num       (p5_num_reg),
        .den       (p5_den_reg),
        .in_side   (p5_side_reg),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .out_side  (dv_side)
    );

    // ---------------- output stage ----------------
    logic signed [QW:0]   nv    [3];
    logic signed [DW-1:0] nv_sat [3];
    logic [2:0]           nv_ovf;

    for (genvar g = 0; g < 3; g++)
    begin : g_norm
        assign nv[g] = dv_side.neg[g] ? -$signed({1'b0, dv_quo[g]})
                                      :  $signed({1'b0, dv_quo[g]});
        v3a_sat #(.IN_W(QW + 1), .OUT_W(DW)) u_sat_nv (
            .din  (nv[g]),
            .dout (nv_sat[g]),
            .ovf  (nv_ovf[g])
        );
    end

    logic          done_reg;
    v3a_pkg::out_t result_reg;
    v3a_pkg::out_t result_next;

    always_comb
    begin
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] ry;
        logic signed [DW-1:0] rz;
        logic                 ovf;
        logic                 zero;
        rx   = dv_side.early[0];
        ry   = dv_side.early[1];
        rz   = dv_side.early[2];
        ovf  = dv_side.sat;
        zero = 1'b0;
        unique case (dv_side.mode)
            v3a_pkg::MODE_NORM:
            begin
                if (dv_side.zero)
                begin
                    rx   = '0;
                    ry   = '0;
                    rz   = '0;
                    ovf  = 1'b0;
                    zero = 1'b1;
                end
                else
                begin
                    rx  = nv_sat[0];
                    ry  = nv_sat[1];
                    rz  = nv_sat[2];
                    ovf = |nv_ovf;
                end
            end
            v3a_pkg::MODE_MAG:
            begin
                rx  = dv_side.mag;
                ry  = '0;
                rz  = '0;
                ovf = dv_side.mag_sat;
            end
            default:
            begin
            end
        endcase
        result_next.result_x = CW'(rx);
        result_next.result_y = CW'(ry);
        result_next.result_z = CW'(rz);
        if (zero)
        begin
            result_next.status = v3a_pkg::ST_ZERO;
        end
        else if (ovf)
        begin
            result_next.status = v3a_pkg::ST_SAT;
        end
        else
        begin
            result_next.status = v3a_pkg::ST_OK;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= mul_valid;
            s4_valid_reg <= s3_valid_reg;
            p5_valid_reg <= sq_valid;
            done_reg     <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_mode_reg   <= mul_out.mode;
        s3_a_reg      <= mul_out.a;
        s3_addsub_reg <= mul_out.addsub;
        s3_sq_reg     <= s3_sq_next;
        for (int i = 0; i < 3; i++)
        begin
            s3_sum_reg[i] <= s3_sum_next[i];
        end
        s4_side_reg <= s4_side_next;
        s4_sq_reg   <= s3_sq_reg;
        p5_side_reg <= p5_side_next;
        p5_num_reg  <= num_next;
        p5_den_reg  <= sq_mag;
        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hdl/v3a_sat.sv]
`default_nettype none

// Signed saturation from IN_W to OUT_W bits
module v3a_sat #(
    parameter int IN_W  = 33,
    parameter int OUT_W = 32
) (
    input  wire logic signed [IN_W-1:0]  din,
    output logic signed [OUT_W-1:0]      dout,
    output logic                         ovf
);

    localparam int EW = ((IN_W > OUT_W) ? IN_W : OUT_W) + 1;
    localparam logic signed [EW-1:0] HI = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EW-1:0] LO = {{(EW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic signed [EW-1:0] ext;
    logic                 over_hi;
    logic                 under_lo;

    assign ext      = EW'(din);
    assign over_hi  = ext > HI;
    assign under_lo = ext < LO;
    assign ovf      = over_hi | under_lo;

    always_comb
    begin
        if (over_hi)
        begin
            dout = HI[OUT_W-1:0];
        end
        else if (under_lo)
        begin
            dout = LO[OUT_W-1:0];
        end
        else
        begin
            dout = ext[OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

[hdl/v3a_mul.sv]
`default_nettype none

// Front end: operand selection, add/subtract, then six 32x32 multipliers
module v3a_mul (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire v3a_pkg::in_t   cmd,
    output logic                out_valid,
    output v3a_pkg::mul_t       out
);

    localparam int CW = v3a_pkg::COMP_W;

    logic                                s1_valid_reg;
    logic [v3a_pkg::MODE_W-1:0]          s1_mode_reg;
    logic [2:0][CW-1:0]                  s1_a_reg;
    logic [2:0][v3a_pkg::AS_W-1:0]       s1_addsub_reg;
    logic [5:0][CW-1:0]                  s1_l_reg;
    logic [5:0][CW-1:0]                  s1_r_reg;

    logic [2:0][CW-1:0]                  a_vec;
    logic [2:0][CW-1:0]                  b_vec;
    logic [2:0][v3a_pkg::AS_W-1:0]       addsub_next;
    logic [5:0][CW-1:0]                  l_next;
    logic [5:0][CW-1:0]                  r_next;

    logic                                s2_valid_reg;
    v3a_pkg::mul_t                       s2_reg;
    v3a_pkg::mul_t                       s2_next;

    assign a_vec = {cmd.az, cmd.ay, cmd.ax};
    assign b_vec = {cmd.bz, cmd.by, cmd.bx};

    // Stage 1: add/subtract and multiplier operand select
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.mode == v3a_pkg::MODE_SUB)
            begin
                addsub_next[i] = v3a_pkg::AS_W'($signed(a_vec[i]))
                               - v3a_pkg::AS_W'($signed(b_vec[i]));
            end
            else
            begin
                addsub_next[i] = v3a_pkg::AS_W'($signed(a_vec[i]))
                               + v3a_pkg::AS_W'($signed(b_vec[i]));
            end
        end
        l_next = {a_vec, a_vec};
        r_next = {b_vec, b_vec};
        unique case (cmd.mode)
            v3a_pkg::MODE_SCALE:
            begin
                r_next[2:0] = {cmd.scale_factor, cmd.scale_factor, cmd.scale_factor};
            end
            v3a_pkg::MODE_NORM, v3a_pkg::MODE_MAG:
            begin
                r_next[2:0] = a_vec;
            end
            v3a_pkg::MODE_CROSS:
            begin
                l_next = {cmd.ay, cmd.ax, cmd.ax, cmd.az, cmd.az, cmd.ay};
                r_next = {cmd.bx, cmd.by, cmd.bz, cmd.bx, cmd.by, cmd.bz};
            end
            default:
            begin
            end
        endcase
    end

    // Stage 2: products
    always_comb
    begin
        s2_next.mode   = s1_mode_reg;
        s2_next.a      = s1_a_reg;
        s2_next.addsub = s1_addsub_reg;
        for (int i = 0; i < 6; i++)
        begin
            s2_next.p[i] = $signed(s1_l_reg[i]) * $signed(s1_r_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg   <= cmd.mode;
        s1_a_reg      <= a_vec;
        s1_addsub_reg <= addsub_next;
        s1_l_reg      <= l_next;
        s1_r_reg      <= r_next;
        s2_reg        <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out       = s2_reg;

endmodule

`default_nettype wire

[hdl/v3a_sqrt.sv]
`default_nettype none

// Pipelined square root, one result bit per stage, rounded to nearest
module v3a_sqrt #(
    parameter int SIDE_W = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [v3a_pkg::SQ_W-1:0]      sq,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [v3a_pkg::MAG_W-1:0]          mag,
    output logic [SIDE_W-1:0]                  out_side
);

    localparam int N  = v3a_pkg::ROOT_W;
    localparam int RW = v3a_pkg::REM_W;
    localparam int SW = v3a_pkg::SQ_W;

    logic [N:0]              valid_reg;
    logic [SW-1:0]           s_reg    [0:N];
    logic [RW-1:0]           rem_reg  [0:N];
    logic [N-1:0]            root_reg [0:N];
    logic [SIDE_W-1:0]       side_reg [0:N];

    logic [SW-1:0]           s_next    [1:N];
    logic [RW-1:0]           rem_next  [1:N];
    logic [N-1:0]            root_next [1:N];

    logic                    fin_valid_reg;
    logic [v3a_pkg::MAG_W-1:0] mag_reg;
    logic [v3a_pkg::MAG_W-1:0] mag_next;
    logic [SIDE_W-1:0]       fin_side_reg;

    // One restoring step per stage
    always_comb
    begin
        logic [RW+1:0] sh;
        logic [RW+1:0] trial;
        for (int k = 1; k <= N; k++)
        begin
            sh    = {rem_reg[k-1], s_reg[k-1][SW-1 -: 2]};
            trial = {2'b00, root_reg[k-1], 2'b01};
            s_next[k] = s_reg[k-1] << 2;
            if (sh >= trial)
            begin
                rem_next[k]  = RW'(sh - trial);
                root_next[k] = {root_reg[k-1][N-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = sh[RW-1:0];
                root_next[k] = {root_reg[k-1][N-2:0], 1'b0};
            end
        end
    end

    // Round up where the remainder exceeds the root
    always_comb
    begin
        if (rem_reg[N] > RW'(root_reg[N]))
        begin
            mag_next = v3a_pkg::MAG_W'(root_reg[N]) + 1'b1;
        end
        else
        begin
            mag_next = v3a_pkg::MAG_W'(root_reg[N]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= {valid_reg[N-1:0], in_valid};
            fin_valid_reg <= valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg[0]    <= sq;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        side_reg[0] <= in_side;
        for (int k = 1; k <= N; k++)
        begin
            s_reg[k]    <= s_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            side_reg[k] <= side_reg[k-1];
        end
        mag_reg      <= mag_next;
        fin_side_reg <= side_reg[N];
    end

    assign out_valid = fin_valid_reg;
    assign mag       = mag_reg;
    assign out_side  = fin_side_reg;

endmodule

`default_nettype wire

[hdl/v3a_div.sv]
`default_nettype none

// Three-lane pipelined restoring divider, one quotient bit per stage
module v3a_div #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic [2:0][v3a_pkg::MAG_W+FRAC_BITS-1:0] num,
    input  wire logic [v3a_pkg::MAG_W-1:0]              den,
    input  wire logic [SIDE_W-1:0]                      in_side,
    output logic                                        out_valid,
    output logic [2:0][FRAC_BITS:0]                     quo,
    output logic [SIDE_W-1:0]                           out_side
);

    localparam int QW = FRAC_BITS + 1;
    localparam int NW = v3a_pkg::MAG_W + FRAC_BITS;
    localparam int MW = v3a_pkg::MAG_W;

    logic [QW:0]             valid_reg;
    logic [2:0][NW-1:0]      num_reg  [0:QW];
    logic [2:0][MW-1:0]      rem_reg  [0:QW];
    logic [2:0][QW-1:0]      q_reg    [0:QW];
    logic [MW-1:0]           den_reg  [0:QW];
    logic [SIDE_W-1:0]       side_reg [0:QW];

    logic [2:0][MW-1:0]      rem_next [1:QW];
    logic [2:0][QW-1:0]      q_next   [1:QW];
    logic [2:0][MW-1:0]      rem_init;

    // Quotient is known to fit QW bits, so start from the top numerator bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rem_init[i] = MW'(num[i][NW-1:QW]);
        end
    end

    always_comb
    begin
        logic [MW:0] sh;
        for (int k = 1; k <= QW; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sh = {rem_reg[k-1][i], num_reg[k-1][i][QW-k]};
                if (sh >= {1'b0, den_reg[k-1]})
                begin
                    rem_next[k][i] = MW'(sh - {1'b0, den_reg[k-1]});
                    q_next[k][i]   = {q_reg[k-1][i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = sh[MW-1:0];
                    q_next[k][i]   = {q_reg[k-1][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0]  <= num;
        rem_reg[0]  <= rem_init;
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
        side_reg[0] <= in_side;
        for (int k = 1; k <= QW; k++)
        begin
            num_reg[k]  <= num_reg[k-1];
            rem_reg[k]  <= rem_next[k];
            q_reg[k]    <= q_next[k];
            den_reg[k]  <= den_reg[k-1];
            side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = q_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

`default_nettype wire

[tb/vector3_alu_tb.sv]
`default_nettype none

module vector3_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import v3a_pkg::*;

    localparam int LATENCY     = 58;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  cmd;
    logic done;
    out_t result;

    out_t expected_results[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   gap_pct;

    vector3_alu DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vector3_alu: mismatch");
            $finish;
        end
    end

    // Round a Q32 sum back to Q16, nearest with ties upward
    function automatic logic signed [71:0] round_q(input logic signed [71:0] acc);
        return (acc + 72'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [71:0] v,
                                                   inout bit ovf);
        if (v > 72'(QMAX))
        begin
            ovf = 1'b1;
            return QMAX;
        end
        if (v < 72'(QMIN))
        begin
            ovf = 1'b1;
            return QMIN;
        end
        return v[31:0];
    endfunction

    // Square root rounded to nearest
    function automatic longint unsigned sqrt_round(input longint unsigned s);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = s;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  -= root + bitv;
                root  = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        if (rem > root)
            root++;
        return root;
    endfunction

    // Expected result of one vector operation
    function automatic out_t vec_predict(input in_t c);
        logic signed [71:0] av[3];
        logic signed [71:0] bv[3];
        logic signed [71:0] sv;
        logic signed [71:0] rv[3];
        logic [71:0]        sq;
        logic [71:0]        mabs;
        logic [71:0]        quo;
        longint unsigned    m;
        bit                 ovf;
        out_t               o;
        av[0] = c.ax; av[1] = c.ay; av[2] = c.az;
        bv[0] = c.bx; bv[1] = c.by; bv[2] = c.bz;
        sv  = c.scale_factor;
        ovf = 1'b0;
        o   = '0;
        o.status = ST_OK;
        for (int i = 0; i < 3; i++)
            rv[i] = '0;
        case (c.mode)
            MODE_ADD:
                for (int i = 0; i < 3; i++)
                    rv[i] = av[i] + bv[i];
            MODE_SUB:
                for (int i = 0; i < 3; i++)
                    rv[i] = av[i] - bv[i];
            MODE_SCALE:
                for (int i = 0; i < 3; i++)
                    rv[i] = round_q(av[i] * sv);
            MODE_NORM, MODE_MAG:
            begin
                sq = av[0] * av[0] + av[1] * av[1] + av[2] * av[2];
                m  = sqrt_round(sq[63:0]);
                if (c.mode == MODE_MAG)
                    rv[0] = 72'(m);
                else if (m == 0)
                    o.status = ST_ZERO;
                else
                    for (int i = 0; i < 3; i++)
                    begin
                        mabs  = (av[i] < 0) ? -av[i] : av[i];
                        quo   = ((mabs << 16) + 72'(m >> 1)) / 72'(m);
                        rv[i] = (av[i] < 0) ? -$signed(quo) : $signed(quo);
                    end
            end
            MODE_DOT:
                rv[0] = round_q(av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2]);
            MODE_CROSS:
            begin
                rv[0] = round_q(av[1] * bv[2] - av[2] * bv[1]);
                rv[1] = round_q(av[2] * bv[0] - av[0] * bv[2]);
                rv[2] = round_q(av[0] * bv[1] - av[1] * bv[0]);
            end
            default: ;
        endcase
        o.result_x = clamp32(rv[0], ovf);
        o.result_y = clamp32(rv[1], ovf);
        o.result_z = clamp32(rv[2], ovf);
        if (ovf && o.status == ST_OK)
            o.status = ST_SAT;
        return o;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.result_x !== want.result_x || result.result_y !== want.result_y
                    || result.result_z !== want.result_z || result.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected x %h y %h z %h st %0d, got x %h y %h z %h st %0d",
                                 want.result_x, want.result_y, want.result_z, want.status,
                                 result.result_x, result.result_y, result.result_z,
                                 result.status);
                end
            end
        end
    end

    // Send one transaction, with a random gap before it
    task automatic send_op(input in_t c);
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        cmd   = c;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(vec_predict(c));
    endtask

    task automatic wait_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic in_t make_op(input logic [MODE_W-1:0] m,
                                    input logic signed [31:0] ax, ay, az, bx, by, bz, s);
        in_t c;
        c.mode = m;
        c.ax = ax; c.ay = ay; c.az = az;
        c.bx = bx; c.by = by; c.bz = bz;
        c.scale_factor = s;
        return c;
    endfunction

    // Component value: full range, small Q16 values, or an extreme
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(9))
            0: return QMAX;
            1: return QMIN;
            2, 3, 4: return $signed($urandom_range(32'h000A_0000)) - 32'sh0005_0000;
            5: return $signed($urandom_range(64)) - 32'sd32;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        gap_pct = 12;
        send_op(make_op(MODE_ADD, QMAX, QMIN, ONE, QMAX, QMIN, -ONE, 0));
        send_op(make_op(MODE_ADD, ONE, -ONE, 5, 7, 3, -9, 0));
        send_op(make_op(MODE_SUB, QMIN, QMAX, 0, QMAX, QMIN, 0, 0));
        send_op(make_op(MODE_SUB, ONE, 2, 3, 4, 5, 6, 0));
        send_op(make_op(MODE_SCALE, QMAX, QMIN, ONE, 0, 0, 0, QMIN));
        send_op(make_op(MODE_SCALE, QMAX, QMIN, -ONE, 0, 0, 0, ONE));
        // ties: +0.5 rounds up, -0.5 rounds toward zero
        send_op(make_op(MODE_SCALE, 1, -1, 3, 0, 0, 0, 32'sh8000));
        send_op(make_op(MODE_SCALE, QMAX, QMAX, QMAX, 0, 0, 0, QMAX));
        // normalize of the zero vector
        send_op(make_op(MODE_NORM, 0, 0, 0, 1, 2, 3, 4));
        send_op(make_op(MODE_NORM, QMAX, QMAX, QMAX, 0, 0, 0, 0));
        send_op(make_op(MODE_NORM, QMIN, 0, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_NORM, 1, 0, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_MAG, QMIN, QMIN, QMIN, 0, 0, 0, 0));
        send_op(make_op(MODE_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_MAG, 0, 0, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_MAG, 1, 1, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_DOT, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 0));
        send_op(make_op(MODE_DOT, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 0));
        send_op(make_op(MODE_DOT, ONE, 2 * ONE, 3 * ONE, -ONE, ONE, 32'sh8000, 0));
        send_op(make_op(MODE_CROSS, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, 0));
        send_op(make_op(MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0));
        // unused operation code gives zeros
        send_op(make_op(MODE_UNUSED, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
        wait_results();
    endtask

    task automatic test_random(input int count, input int pct);
        in_t c;
        gap_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            c.mode = MODE_W'($urandom_range(7));
            c.ax = rand_comp(); c.ay = rand_comp(); c.az = rand_comp();
            c.bx = rand_comp(); c.by = rand_comp(); c.bz = rand_comp();
            c.scale_factor = rand_comp();
            if (c.mode == MODE_NORM && $urandom_range(15) == 0)
            begin
                c.ax = 0; c.ay = 0; c.az = 0;
            end
            send_op(c);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        gap_pct    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(520, 12);
        // hold off until the pipeline has drained
        wait_results();
        test_random(520, 76);
        test_random(490, 0);
        wait_results();
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("vector3_alu: match");
        else
            $display("vector3_alu: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/v3a_pkg.sv
hdl/v3a_sat.sv
hdl/v3a_mul.sv
hdl/v3a_sqrt.sv
hdl/v3a_div.sv
hdl/vector3_alu.sv
tb/vector3_alu_tb.sv
